@@ hw/rtl/ispd_pkg.sv @@
// ----------------------------------------------------------------------------
// ispd_pkg
// Shared types, opcodes and mnemonic codes for the instruction predecoder.
// ----------------------------------------------------------------------------
package ispd_pkg;

    localparam int unsigned WindowBytes = 5;
    localparam int unsigned AddrW       = 64;
    localparam int unsigned OffW        = 34;   // signed displacement plus length
    localparam int unsigned ApbAddrW    = 3;

    // register map (byte addresses)
    localparam logic [ApbAddrW-1:0] RegIsaMode = 3'h0;

    // ISA select
    localparam logic IsaX86 = 1'b0;
    localparam logic IsaArm = 1'b1;

    // x86 opcodes
    localparam logic [7:0] OpPushRbp = 8'h55;
    localparam logic [7:0] OpPushLo  = 8'h50;
    localparam logic [7:0] OpPushHi  = 8'h57;
    localparam logic [7:0] OpPopLo   = 8'h58;
    localparam logic [7:0] OpPopHi   = 8'h5F;
    localparam logic [7:0] OpJccLo   = 8'h74;
    localparam logic [7:0] OpJccHi   = 8'h79;   // last jcc decoded with rel8
    localparam logic [7:0] OpJccName = 8'h7F;   // last jcc with a known name
    localparam logic [7:0] OpMov     = 8'h89;
    localparam logic [7:0] OpNop     = 8'h90;
    localparam logic [7:0] OpRet     = 8'hC3;
    localparam logic [7:0] OpCall    = 8'hE8;
    localparam logic [7:0] OpJmp     = 8'hE9;
    localparam logic [7:0] OpJmpRel8 = 8'hEB;

    // ARM class codes (word bits 27:24)
    localparam logic [3:0] ArmClsMovHi = 4'h1;
    localparam logic [3:0] ArmClsAddHi = 4'h3;
    localparam logic [3:0] ArmClsB     = 4'hA;
    localparam logic [3:0] ArmClsBl    = 4'hB;

    localparam logic [2:0] LenZero  = 3'd0;
    localparam logic [2:0] LenByte  = 3'd1;
    localparam logic [2:0] LenRel8  = 3'd2;
    localparam logic [2:0] LenMin   = 3'd3;   // minimum window for a prologue
    localparam logic [2:0] LenWord  = 3'd4;
    localparam logic [2:0] LenRel32 = 3'd5;

    typedef enum logic [4:0] {
        MN_DB       = 5'd0,
        MN_PUSH     = 5'd1,
        MN_POP      = 5'd2,
        MN_MOV      = 5'd3,
        MN_NOP      = 5'd4,
        MN_RET      = 5'd5,
        MN_CALL     = 5'd6,
        MN_JMP      = 5'd7,
        MN_JZ       = 5'd8,
        MN_JNZ      = 5'd9,
        MN_JBE      = 5'd10,
        MN_JA       = 5'd11,
        MN_JS       = 5'd12,
        MN_JNS      = 5'd13,
        MN_JP       = 5'd14,
        MN_JNP      = 5'd15,
        MN_JL       = 5'd16,
        MN_JGE      = 5'd17,
        MN_JLE      = 5'd18,
        MN_JG       = 5'd19,
        MN_ARM_MOV  = 5'd20,
        MN_ARM_ADD  = 5'd21,
        MN_ARM_B    = 5'd22,
        MN_ARM_UNK  = 5'd23
    } ispd_mnemonic_t;

    typedef struct packed {
        logic [WindowBytes-1:0][7:0] bytes;
        logic [2:0]                  avail;
        logic [AddrW-1:0]            address;
    } ispd_window_t;

    typedef struct packed {
        logic           ok;
        logic [2:0]     length;
        ispd_mnemonic_t mnemonic;
        logic [2:0]     first_register;
        logic [2:0]     second_register;
        logic           memory_operand;
        logic           is_jump;
        logic [AddrW-1:0] branch_target;
        logic           func_start;
    } ispd_result_t;

    function automatic ispd_mnemonic_t x86_mnemonic(input logic [7:0] op);
        ispd_mnemonic_t mn;
        mn = MN_DB;
        if (op >= OpPushLo && op <= OpPushHi) begin
            mn = MN_PUSH;
        end
        else if (op >= OpPopLo && op <= OpPopHi) begin
            mn = MN_POP;
        end
        else if (op >= OpJccLo && op <= OpJccName) begin
            mn = ispd_mnemonic_t'(5'(MN_JZ) + 5'(op[3:0] - OpJccLo[3:0]));
        end
        else begin
            unique case (op)
                OpMov:     mn = MN_MOV;
                OpNop:     mn = MN_NOP;
                OpRet:     mn = MN_RET;
                OpCall:    mn = MN_CALL;
                OpJmp:     mn = MN_JMP;
                OpJmpRel8: mn = MN_JMP;
                default:   mn = MN_DB;
            endcase
        end
        return mn;
    endfunction

endpackage

@@ hw/rtl/ispd_apb_regs.sv @@
// ----------------------------------------------------------------------------
// ispd_apb_regs
// APB register file: holds the ISA mode select.
// ----------------------------------------------------------------------------
module ispd_apb_regs
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [ispd_pkg::ApbAddrW-1:0] paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready,
    output logic                          isa_mode
);
    import ispd_pkg::*;

    logic isa_mode_reg;
    logic isa_mode_next;
    logic hit;

    // word decode, byte offset ignored
    assign hit    = (paddr[ApbAddrW-1:2] == RegIsaMode[ApbAddrW-1:2]);
    assign pready = 1'b1;

    always_comb
    begin
        isa_mode_next = isa_mode_reg;
        if (psel && penable && pwrite && hit) begin
            isa_mode_next = pwdata[0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            isa_mode_reg <= IsaX86;
        end
        else begin
            isa_mode_reg <= isa_mode_next;
        end
    end

    assign prdata   = hit ? {31'd0, isa_mode_reg} : 32'd0;
    assign isa_mode = isa_mode_reg;

endmodule

@@ hw/rtl/ispd_decode.sv @@
// ----------------------------------------------------------------------------
// ispd_decode
// Combinational decode of one fetch window into a predecode result.
// ----------------------------------------------------------------------------
module ispd_decode
(
    input  logic                   isa_mode,
    input  ispd_pkg::ispd_window_t win,
    output ispd_pkg::ispd_result_t res
);
    import ispd_pkg::*;

    logic [2:0]        avail;
    logic [7:0]        op;
    logic [7:0]        modrm;
    logic [3:0]        cls;
    logic              ok;
    logic              jump;
    logic [OffW-1:0]   offset;      // displacement plus length, signed
    ispd_result_t      r;

    assign avail = (win.avail > LenRel32) ? LenRel32 : win.avail;
    assign op    = win.bytes[0];
    assign modrm = win.bytes[1];
    assign cls   = win.bytes[3][3:0];

    always_comb
    begin
        r        = '0;
        r.mnemonic = MN_DB;
        ok       = 1'b1;
        jump     = 1'b0;
        offset   = '0;
        if (isa_mode == IsaArm) begin
            r.length = LenWord;
            if (avail < LenWord) begin
                ok = 1'b0;
            end
            else if (cls <= ArmClsMovHi) begin
                r.mnemonic = MN_ARM_MOV;
            end
            else if (cls <= ArmClsAddHi) begin
                r.mnemonic = MN_ARM_ADD;
            end
            else if (cls == ArmClsB || cls == ArmClsBl) begin
                r.mnemonic = MN_ARM_B;
                jump       = 1'b1;
                // imm24 * 4, sign-extended
                offset = {{(OffW-26){win.bytes[2][7]}},
                          win.bytes[2], win.bytes[1], win.bytes[0], 2'b00};
            end
            else begin
                r.mnemonic = MN_ARM_UNK;
            end
        end
        else begin
            r.mnemonic = x86_mnemonic(op);
            r.length   = LenByte;
            if (avail == LenZero) begin
                ok = 1'b0;
            end
            else if (op >= OpPushLo && op <= OpPopHi) begin
                r.first_register = op[2:0];
            end
            else if (op == OpCall || op == OpJmp) begin
                if (avail < LenRel32) begin
                    ok = 1'b0;
                end
                else begin
                    r.length = LenRel32;
                    jump     = 1'b1;
                    offset   = {{(OffW-32){win.bytes[4][7]}}, win.bytes[4],
                                win.bytes[3], win.bytes[2], win.bytes[1]}
                             + OffW'(LenRel32);
                end
            end
            else if (op >= OpJccLo && op <= OpJccHi) begin
                if (avail < LenRel8) begin
                    ok = 1'b0;
                end
                else begin
                    r.length = LenRel8;
                    jump     = 1'b1;
                    offset   = {{(OffW-8){modrm[7]}}, modrm} + OffW'(LenRel8);
                end
            end
            else if (op == OpMov) begin
                if (avail < LenRel8) begin
                    ok = 1'b0;
                end
                else begin
                    r.length          = LenRel8;
                    r.first_register  = modrm[2:0];
                    r.second_register = modrm[5:3];
                    r.memory_operand  = (modrm[7:6] != 2'b11);
                end
            end
            r.func_start = (op == OpPushRbp) && (avail >= LenMin);
        end

        r.ok            = ok;
        r.is_jump       = jump;
        r.branch_target = jump ? (win.address + {{(AddrW-OffW){offset[OffW-1]}}, offset})
                               : '0;
        if (!ok) begin
            r          = '0;
            r.mnemonic = MN_DB;
        end
    end

    assign res = r;

endmodule

@@ hw/rtl/isa_subset_instruction_predecoder_top.sv @@
// ----------------------------------------------------------------------------
// Path: an accepted window fills the window reg, its decode the result reg.
// Throughput: one window per cycle unless the output stalls; the single decode
//   pass between the two registers sets the rate, and a stalled result still
//   lets one more window in.
// Reset: rst_n clears both stage valids and sets isa_mode to x86 decode.
// ----------------------------------------------------------------------------
// isa_subset_instruction_predecoder_top
// Instruction predecoder: x86 subset or ARM word, length, mnemonic, branch target.
// ----------------------------------------------------------------------------
module isa_subset_instruction_predecoder_top
(
    input  logic                          clk,
    input  logic                          rst_n,

    // APB configuration
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [ispd_pkg::ApbAddrW-1:0] paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready,

    // window input channel
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [7:0]                    byte0,
    input  logic [7:0]                    byte1,
    input  logic [7:0]                    byte2,
    input  logic [7:0]                    byte3,
    input  logic [7:0]                    byte4,
    input  logic [2:0]                    bytes_available,
    input  logic [63:0]                   address,

    // result output channel
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic                          ok,
    output logic [2:0]                    length,
    output logic [4:0]                    mnemonic,
    output logic [2:0]                    first_register,
    output logic [2:0]                    second_register,
    output logic                          memory_operand,
    output logic                          is_jump,
    output logic [63:0]                   branch_target,
    output logic                          func_start
);
    import ispd_pkg::*;

    logic          isa_mode;

    // stage 1: captured window
    logic          win_valid_reg;
    logic          win_valid_next;
    ispd_window_t  win_reg;

    // stage 2: decoded result
    logic          res_valid_reg;
    logic          res_valid_next;
    ispd_result_t  res_reg;
    ispd_result_t  res_next;

    logic          in_xfer;
    logic          res_load;

    ispd_apb_regs u_regs
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .isa_mode (isa_mode)
    );

    ispd_decode u_decode
    (
        .isa_mode (isa_mode),
        .win      (win_reg),
        .res      (res_next)
    );

    // Result register loads when it is empty or its content is being taken.
    // The window register empties into it, so it can refill in the same cycle.
    assign res_load = win_valid_reg && (!res_valid_reg || out_ready);
    assign in_ready = !win_valid_reg || res_load;
    assign in_xfer  = in_valid && in_ready;

    always_comb
    begin
        win_valid_next = win_valid_reg;
        if (in_xfer) begin
            win_valid_next = 1'b1;
        end
        else if (res_load) begin
            win_valid_next = 1'b0;
        end

        res_valid_next = res_valid_reg;
        if (res_load) begin
            res_valid_next = 1'b1;
        end
        else if (out_ready) begin
            res_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            win_valid_reg <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else begin
            win_valid_reg <= win_valid_next;
            res_valid_reg <= res_valid_next;
        end
    end

    // payload registers, no reset needed
    always_ff @(posedge clk)
    begin
        if (in_xfer) begin
            win_reg.bytes   <= {byte4, byte3, byte2, byte1, byte0};
            win_reg.avail   <= bytes_available;
            win_reg.address <= address;
        end
        if (res_load) begin
            res_reg <= res_next;
        end
    end

    assign out_valid       = res_valid_reg;
    assign ok              = res_reg.ok;
    assign length          = res_reg.length;
    assign mnemonic        = res_reg.mnemonic;
    assign first_register  = res_reg.first_register;
    assign second_register = res_reg.second_register;
    assign memory_operand  = res_reg.memory_operand;
    assign is_jump         = res_reg.is_jump;
    assign branch_target   = res_reg.branch_target;
    assign func_start      = res_reg.func_start;

    // a failed decode carries no length and no branch
    a_fail_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (res_load && !res_next.ok) |=> (length == LenZero && !is_jump && !func_start))
        else $error("failed decode left fields set");

    // a branch is only reported for a decoded instruction
    a_jump_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && is_jump) |-> ok)
        else $error("jump flagged on failed decode");

    // an empty window stage always takes input
    a_ready_free: assert property (@(posedge clk) disable iff (!rst_n)
        !win_valid_reg |-> in_ready)
        else $error("input stalled with empty window stage");

    // a held result is not overwritten
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |-> !res_load)
        else $error("result register reloaded while stalled");

    // function start implies a push decode
    a_func_push: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && func_start) |-> (ok && mnemonic == MN_PUSH))
        else $error("function start without push");

endmodule

@@ sim/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the instruction predecoder. A directed pass covers
// each x86 opcode group, short windows and ARM word classes; random windows
// follow across several isa_mode settings with random stalls on both
// channels. An in-bench decode predictor queues one expected result per
// accepted window, and each returned result is compared field by field.
// ----------------------------------------------------------------------------
module testbench;

    timeunit 1ns;
    timeprecision 1ps;

    import ispd_pkg::*;

    localparam int unsigned WatchdogLimit = 2000;  // cycles with no transfer
    localparam int unsigned DrainCycles   = 4;     // two-stage pipe plus margin
    localparam int unsigned ReportLimit   = 10;

    // opcodes the random windows lean on
    localparam logic [7:0] KnownOps [12] = '{
        OpPushRbp, OpPushLo, OpPopHi, OpJccLo, OpJccHi, OpJccName,
        OpMov, OpNop, OpRet, OpCall, OpJmp, OpJmpRel8
    };

    // ------------------------------------------------------------------------
    // DUT connections; every input starts at a known value
    // ------------------------------------------------------------------------
    logic                clk = 1'b0;
    logic                rst_n = 1'b0;

    logic                psel = 1'b0;
    logic                penable = 1'b0;
    logic                pwrite = 1'b0;
    logic [ApbAddrW-1:0] paddr = '0;
    logic [31:0]         pwdata = '0;
    logic [31:0]         prdata;
    logic                pready;

    logic                in_valid = 1'b0;
    logic                in_ready;
    logic [7:0]          byte0 = '0;
    logic [7:0]          byte1 = '0;
    logic [7:0]          byte2 = '0;
    logic [7:0]          byte3 = '0;
    logic [7:0]          byte4 = '0;
    logic [2:0]          bytes_available = '0;
    logic [63:0]         address = '0;

    logic                out_valid;
    logic                out_ready = 1'b0;
    logic                ok;
    logic [2:0]          length;
    logic [4:0]          mnemonic;
    logic [2:0]          first_register;
    logic [2:0]          second_register;
    logic                memory_operand;
    logic                is_jump;
    logic [63:0]         branch_target;
    logic                func_start;

    // ------------------------------------------------------------------------
    // bench state
    // ------------------------------------------------------------------------
    ispd_result_t decode_queue [$];      // expected decodes, oldest first
    logic         isa_mode_shadow = IsaX86;
    logic         idle_on = 1'b1;        // random gaps on both channels
    int unsigned  fault_count = 0;
    int unsigned  quiet_cycles = 0;

    isa_subset_instruction_predecoder_top dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .byte0           (byte0),
        .byte1           (byte1),
        .byte2           (byte2),
        .byte3           (byte3),
        .byte4           (byte4),
        .bytes_available (bytes_available),
        .address         (address),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .ok              (ok),
        .length          (length),
        .mnemonic        (mnemonic),
        .first_register  (first_register),
        .second_register (second_register),
        .memory_operand  (memory_operand),
        .is_jump         (is_jump),
        .branch_target   (branch_target),
        .func_start      (func_start)
    );

    initial
    begin
        forever
        begin
            #4 clk = ~clk;
        end
    end

    // ------------------------------------------------------------------------
    // Decode predictor. Stateless apart from the ISA select; a short window
    // zeroes the whole result.
    // ------------------------------------------------------------------------
    function automatic ispd_result_t predict_decode(input logic arm_mode,
                                                    input ispd_window_t w);
        ispd_result_t r;
        logic [2:0]   avail;
        logic [7:0]   op;
        logic [31:0]  word;
        logic [31:0]  rel;
        r     = '0;
        r.ok  = 1'b1;
        avail = (w.avail > LenRel32) ? LenRel32 : w.avail;  // 6 and 7 saturate
        op    = w.bytes[0];
        word  = {w.bytes[3], w.bytes[2], w.bytes[1], w.bytes[0]};
        rel   = {w.bytes[4], w.bytes[3], w.bytes[2], w.bytes[1]};

        if (arm_mode == IsaArm)
        begin
            if (avail < LenWord)
            begin
                r.ok = 1'b0;
            end
            else
            begin
                r.length = LenWord;
                if (word[27:24] <= ArmClsMovHi)
                begin
                    r.mnemonic = MN_ARM_MOV;
                end
                else if (word[27:24] <= ArmClsAddHi)
                begin
                    r.mnemonic = MN_ARM_ADD;
                end
                else if (word[27:24] == ArmClsB || word[27:24] == ArmClsBl)
                begin
                    r.mnemonic      = MN_ARM_B;
                    r.is_jump       = 1'b1;
                    r.branch_target = w.address + {{38{word[23]}}, word[23:0], 2'b00};
                end
                else
                begin
                    r.mnemonic = MN_ARM_UNK;
                end
            end
        end
        else if (avail == LenZero)
        begin
            r.ok = 1'b0;
        end
        else
        begin
            // name first; names reach past what actually decodes (jp..jg, short jmp)
            if (op >= OpPushLo && op <= OpPushHi)
            begin
                r.mnemonic = MN_PUSH;
            end
            else if (op >= OpPopLo && op <= OpPopHi)
            begin
                r.mnemonic = MN_POP;
            end
            else if (op >= OpJccLo && op <= OpJccName)
            begin
                r.mnemonic = ispd_mnemonic_t'(5'(int'(MN_JZ) + int'(op - OpJccLo)));
            end
            else if (op == OpMov)
            begin
                r.mnemonic = MN_MOV;
            end
            else if (op == OpNop)
            begin
                r.mnemonic = MN_NOP;
            end
            else if (op == OpRet)
            begin
                r.mnemonic = MN_RET;
            end
            else if (op == OpCall)
            begin
                r.mnemonic = MN_CALL;
            end
            else if (op == OpJmp || op == OpJmpRel8)
            begin
                r.mnemonic = MN_JMP;
            end

            // then length and operands
            r.length = LenByte;
            if (op >= OpPushLo && op <= OpPopHi)
            begin
                r.first_register = op[2:0];
            end
            else if (op == OpCall || op == OpJmp)
            begin
                if (avail < LenRel32)
                begin
                    r.ok = 1'b0;
                end
                else
                begin
                    r.length        = LenRel32;
                    r.is_jump       = 1'b1;
                    r.branch_target = w.address + 64'd5 + {{32{rel[31]}}, rel};
                end
            end
            else if (op >= OpJccLo && op <= OpJccHi)
            begin
                if (avail < LenRel8)
                begin
                    r.ok = 1'b0;
                end
                else
                begin
                    r.length        = LenRel8;
                    r.is_jump       = 1'b1;
                    r.branch_target = w.address + 64'd2
                                    + {{56{w.bytes[1][7]}}, w.bytes[1]};
                end
            end
            else if (op == OpMov)
            begin
                if (avail < LenRel8)
                begin
                    r.ok = 1'b0;
                end
                else
                begin
                    r.length          = LenRel8;
                    r.first_register  = w.bytes[1][2:0];
                    r.second_register = w.bytes[1][5:3];
                    r.memory_operand  = (w.bytes[1][7:6] != 2'b11);
                end
            end
            r.func_start = r.ok && op == OpPushRbp && avail >= LenMin;
        end

        if (!r.ok)
        begin
            r = '0;
        end
        return r;
    endfunction

    function automatic ispd_window_t make_window(input logic [7:0] b0, input logic [7:0] b1,
                                                 input logic [7:0] b2, input logic [7:0] b3,
                                                 input logic [7:0] b4, input logic [2:0] avail,
                                                 input logic [63:0] addr);
        ispd_window_t w;
        w.bytes   = {b4, b3, b2, b1, b0};
        w.avail   = avail;
        w.address = addr;
        return w;
    endfunction

    // Random window: mostly full windows around known opcodes, addresses
    // clustered near both ends of the space so targets wrap.
    function automatic ispd_window_t random_window(input logic arm_mode);
        ispd_window_t w;
        w.bytes = 40'({$urandom(), $urandom()});
        if (arm_mode == IsaX86)
        begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4, 5: w.bytes[0] = KnownOps[$urandom_range(0, 11)];
                6:                w.bytes[0] = 8'($urandom_range(OpPushLo, OpPopHi));
                7:                w.bytes[0] = 8'($urandom_range(OpJccLo, OpJccName));
                default:          ;
            endcase
        end
        w.avail = ($urandom_range(0, 9) < 6) ? LenRel32 : 3'($urandom_range(0, 7));
        case ($urandom_range(0, 7))
            0:       w.address = '1 - 64'($urandom_range(0, 8));
            1:       w.address = 64'($urandom_range(0, 8));
            default: w.address = {$urandom(), $urandom()};
        endcase
        return w;
    endfunction

    // ------------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------------

    // One window transfer; valid stays up on return so back-to-back calls
    // stream without a bubble.
    task automatic send_window(input ispd_window_t w);
        if (idle_on && $urandom_range(0, 5) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge clk);
        end
        in_valid        <= 1'b1;
        byte0           <= w.bytes[0];
        byte1           <= w.bytes[1];
        byte2           <= w.bytes[2];
        byte3           <= w.bytes[3];
        byte4           <= w.bytes[4];
        bytes_available <= w.avail;
        address         <= w.address;
        do
        begin
            @(posedge clk);
        end
        while (!in_ready);
        decode_queue.insert(decode_queue.size(), predict_decode(isa_mode_shadow, w));
    endtask

    // Stop sending and let the pipe empty.
    task automatic wait_idle();
        in_valid <= 1'b0;
        while (decode_queue.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DrainCycles) @(posedge clk);
    endtask

    // APB write: setup then access; upper data bits are junk the block drops.
    task automatic write_isa_mode(input logic mode);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= RegIsaMode;
        pwdata  <= {31'($urandom()), mode};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        isa_mode_shadow = mode;
    endtask

    // Result side pacing: random stall bursts while idling is on.
    initial
    begin : sink_pacing
        int hold;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (idle_on && $urandom_range(0, 7) == 0)
            begin
                hold = $urandom_range(1, 14);
                out_ready <= 1'b0;
                repeat (hold) @(posedge clk);
            end
            out_ready <= 1'b1;
        end
    end

    // ------------------------------------------------------------------------
    // Checking
    // ------------------------------------------------------------------------
    task automatic note_fault(input string msg);
        fault_count++;
        if (fault_count <= ReportLimit)
        begin
            $display("[%0t] MISMATCH %s", $realtime, msg);
        end
    endtask

    task automatic check_field(input string name, input logic [63:0] got,
                               input logic [63:0] want);
        if (got !== want)
        begin
            note_fault($sformatf("%s: expected 0x%0h, got 0x%0h", name, want, got));
        end
    endtask

    // Every result transfer is matched against the oldest pending decode.
    always @(posedge clk)
    begin : result_check
        ispd_result_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (decode_queue.size() == 0)
            begin
                note_fault($sformatf("unexpected result, mnemonic %0d target 0x%0h",
                                     mnemonic, branch_target));
            end
            else
            begin
                want = decode_queue.pop_front();
                check_field("ok", 64'(ok), 64'(want.ok));
                check_field("length", 64'(length), 64'(want.length));
                check_field("mnemonic", 64'(mnemonic), 64'(want.mnemonic));
                check_field("first_register", 64'(first_register),
                            64'(want.first_register));
                check_field("second_register", 64'(second_register),
                            64'(want.second_register));
                check_field("memory_operand", 64'(memory_operand),
                            64'(want.memory_operand));
                check_field("is_jump", 64'(is_jump), 64'(want.is_jump));
                check_field("branch_target", branch_target, want.branch_target);
                check_field("func_start", 64'(func_start), 64'(want.func_start));
            end
        end
    end

    // Watchdog: any transfer on either channel counts as progress.
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
        begin
            quiet_cycles <= 0;
        end
        else if (quiet_cycles >= WatchdogLimit)
        begin
            $display("[%0t] watchdog expired, %0d decodes pending",
                     $realtime, decode_queue.size());
            $display("testbench: errors");
            $finish;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // x86 groups at reset mode: every opcode family, short windows, the
    // oversized count, mnemonics named but decoded as one byte, wrap both ways.
    task automatic test_x86_directed();
        send_window(make_window(OpNop, 8'h00, 8'h00, 8'h00, 8'h00, 3'd1, 64'h1000));
        send_window(make_window(OpRet, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 3'd5, 64'h1001));
        send_window(make_window(OpPushRbp, 8'h48, 8'h89, 8'hE5, 8'h00, 3'd3, 64'h2000));
        send_window(make_window(OpPushRbp, 8'h48, 8'h89, 8'hE5, 8'h00, 3'd2, 64'h2000));
        send_window(make_window(OpPushLo, 8'h00, 8'h00, 8'h00, 8'h00, 3'd5, 64'h2100));
        send_window(make_window(OpPopHi, 8'h00, 8'h00, 8'h00, 8'h00, 3'd1, 64'h2200));
        send_window(make_window(OpMov, 8'hC3, 8'h00, 8'h00, 8'h00, 3'd2, 64'h3000));
        send_window(make_window(OpMov, 8'h7D, 8'hF8, 8'h00, 8'h00, 3'd5, 64'h3002));
        send_window(make_window(OpMov, 8'hE5, 8'h00, 8'h00, 8'h00, 3'd1, 64'h3004));
        send_window(make_window(OpCall, 8'h10, 8'h00, 8'h00, 8'h00, 3'd5, 64'h400000));
        send_window(make_window(OpCall, 8'h00, 8'h00, 8'h00, 8'h80, 3'd5, 64'h0));
        send_window(make_window(OpJmp, 8'h00, 8'h00, 8'h00, 8'h00, 3'd4, 64'h5000));
        send_window(make_window(OpJmp, 8'hFF, 8'hFF, 8'hFF, 8'h7F, 3'd5, '1));
        send_window(make_window(OpJccLo, 8'h80, 8'h00, 8'h00, 8'h00, 3'd2, 64'h0));
        send_window(make_window(OpJccHi, 8'h7F, 8'h00, 8'h00, 8'h00, 3'd7, 64'h6000));
        send_window(make_window(OpJccLo, 8'h10, 8'h00, 8'h00, 8'h00, 3'd1, 64'h6100));
        send_window(make_window(8'h7A, 8'h10, 8'h00, 8'h00, 8'h00, 3'd5, 64'h6200));
        send_window(make_window(OpJccName, 8'hF0, 8'h00, 8'h00, 8'h00, 3'd5, 64'h6300));
        send_window(make_window(OpJmpRel8, 8'h10, 8'h00, 8'h00, 8'h00, 3'd5, 64'h6400));
        send_window(make_window(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 3'd6, '1));
        send_window(make_window(OpNop, 8'h00, 8'h00, 8'h00, 8'h00, 3'd0, 64'h7000));
    endtask

    // ARM words: each class range, both branch encodings, extreme offsets.
    task automatic test_arm_directed();
        wait_idle();
        write_isa_mode(IsaArm);
        send_window(make_window(8'h00, 8'h00, 8'hA0, 8'hE1, 8'h00, 3'd4, 64'h8000));
        send_window(make_window(8'h01, 8'h00, 8'h80, 8'hE2, 8'h00, 3'd5, 64'h8004));
        send_window(make_window(8'hFE, 8'hFF, 8'hFF, 8'hEA, 8'h00, 3'd4, 64'h8008));
        send_window(make_window(8'hFF, 8'hFF, 8'h7F, 8'hEB, 8'h00, 3'd5, '1));
        send_window(make_window(8'h00, 8'h00, 8'h80, 8'h0A, 8'h00, 3'd6, 64'h0));
        send_window(make_window(8'h00, 8'h00, 8'h00, 8'hEF, 8'h00, 3'd4, 64'h800C));
        send_window(make_window(8'h00, 8'h00, 8'h00, 8'hEA, 8'h00, 3'd3, 64'h8010));
    endtask

    // Random windows in phases; each phase starts from an idle pipe with a
    // fresh mode, so the sender repeatedly waits for every result first.
    task automatic test_random_windows(input int unsigned phases, input int unsigned per_phase);
        logic mode;
        for (int unsigned p = 0; p < phases; p++)
        begin
            mode = (p % 4 == 3) ? 1'($urandom_range(0, 1)) : p[0];
            wait_idle();
            write_isa_mode(mode);
            idle_on = (p == 4) ? 1'b0 : ($urandom_range(0, 3) != 0);
            for (int unsigned i = 0; i < per_phase; i++)
            begin
                send_window(random_window(isa_mode_shadow));
            end
        end
    endtask

    // Full-rate tail: no gaps, no stalls, both modes, ending back at x86.
    task automatic test_steady_stream(input int unsigned count);
        wait_idle();
        idle_on = 1'b0;
        write_isa_mode(IsaArm);
        for (int unsigned i = 0; i < count; i++)
        begin
            send_window(random_window(isa_mode_shadow));
        end
        wait_idle();
        write_isa_mode(IsaX86);
        for (int unsigned i = 0; i < count; i++)
        begin
            send_window(random_window(isa_mode_shadow));
        end
    endtask

    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_x86_directed();
        test_arm_directed();
        test_random_windows(10, 150);
        test_steady_stream(110);

        wait_idle();
        if (decode_queue.size() != 0)
        begin
            note_fault($sformatf("%0d decodes never returned", decode_queue.size()));
        end
        if (fault_count == 0)
        begin
            $display("testbench: clean");
        end
        else
        begin
            $display("testbench: errors");
        end
        $finish;
    end

endmodule
